FILE: hw/rtl/ats_pkg.sv
package ats_pkg;

  localparam int unsigned LINE_COLUMNS = 256;
  localparam int unsigned VALUE_BITS   = 32;
  localparam int unsigned ColW         = $clog2(LINE_COLUMNS);
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned FifoPtrW     = $clog2(FifoDepth);
  localparam int unsigned FifoCntW     = $clog2(FifoDepth + 1);

  typedef enum logic [4:0] {
    K_ADD     = 5'd0,
    K_SUB     = 5'd1,
    K_STAR    = 5'd2,
    K_SLASH   = 5'd3,
    K_AND     = 5'd4,
    K_OR      = 5'd5,
    K_NOT     = 5'd6,
    K_POSTINC = 5'd7,
    K_PREDEC  = 5'd8,
    K_SHL     = 5'd9,
    K_SHR     = 5'd10,
    K_LT      = 5'd11,
    K_GT      = 5'd12,
    K_EQ      = 5'd13,
    K_IMM     = 5'd14,
    K_INDIR   = 5'd15,
    K_LPAREN  = 5'd16,
    K_RPAREN  = 5'd17,
    K_LBRACK  = 5'd18,
    K_RBRACK  = 5'd19,
    K_COMMA   = 5'd20,
    K_COLON   = 5'd21,
    K_MACRO   = 5'd22,
    K_STRING  = 5'd23,
    K_OTHER   = 5'd24,
    K_INT     = 5'd25,
    K_IDENT   = 5'd26,
    K_EOL     = 5'd27
  } kind_e;

  typedef enum logic [3:0] {
    CC_TOKEN,
    CC_WS,
    CC_EOL,
    CC_PLUS,
    CC_MINUS,
    CC_LT,
    CC_GT,
    CC_QUOTE,
    CC_HEX,
    CC_BIN,
    CC_DIGIT,
    CC_IDENT
  } char_class_e;

  typedef enum logic [9:0] {
    M_IDLE    = 10'b0000000001,
    M_PLUS    = 10'b0000000010,
    M_MINUS   = 10'b0000000100,
    M_LT      = 10'b0000001000,
    M_GT      = 10'b0000010000,
    M_QUOTE   = 10'b0000100000,
    M_ZERO    = 10'b0001000000,
    M_NUMBER  = 10'b0010000000,
    M_IDENT   = 10'b0100000000,
    M_DISCARD = 10'b1000000000
  } mode_e;

  typedef struct packed {
    char_class_e cc;
    kind_e       kind;
  } char_info_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [7:0]  start;
    logic [7:0]  len;
    logic        last;
  } result_t;

  // up to two tokens per scanned byte, r0 first
  typedef struct packed {
    result_t    r0;
    result_t    r1;
    logic [1:0] n;
  } scan_out_t;

  function automatic char_info_t classify(input logic [7:0] c);
    char_info_t ci;
    ci.cc   = CC_TOKEN;
    ci.kind = K_OTHER;
    if (c == 8'h00 || c == 8'h0a) begin
      ci.cc = CC_EOL;
    end else if (c < 8'h20 || c >= 8'h80 || c == " ") begin
      ci.cc = CC_WS;
    end else if (c >= "0" && c <= "9") begin
      ci.cc = CC_DIGIT;
    end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_" || c == ".") begin
      ci.cc = CC_IDENT;
    end else begin
      case (c)
        "!", ";": ci.cc = CC_EOL;
        "\"":     ci.kind = K_STRING;
        "#":      ci.kind = K_IMM;
        "$":      ci.cc = CC_HEX;
        "%":      ci.cc = CC_BIN;
        "&":      ci.kind = K_AND;
        "'":      ci.cc = CC_QUOTE;
        "(":      ci.kind = K_LPAREN;
        ")":      ci.kind = K_RPAREN;
        "*":      ci.kind = K_STAR;
        "+":      ci.cc = CC_PLUS;
        ",":      ci.kind = K_COMMA;
        "-":      ci.cc = CC_MINUS;
        "/":      ci.kind = K_SLASH;
        ":":      ci.kind = K_COLON;
        "<":      ci.cc = CC_LT;
        "=":      ci.kind = K_EQ;
        ">":      ci.cc = CC_GT;
        "?":      ci.kind = K_MACRO;
        "@":      ci.kind = K_INDIR;
        "[":      ci.kind = K_LBRACK;
        "]":      ci.kind = K_RBRACK;
        "|":      ci.kind = K_OR;
        "~":      ci.kind = K_NOT;
        default:  ci.kind = K_OTHER;
      endcase
    end
    return ci;
  endfunction

endpackage

FILE: hw/rtl/ats_scan_core.sv
module ats_scan_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output ats_pkg::scan_out_t scan_o
);
  import ats_pkg::*;

  mode_e                 mode_q, mode_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [4:0]            radix_q, radix_d;
  logic [ColW-1:0]       col_q, col_d;
  logic [ColW-1:0]       start_q, start_d;

  char_info_t            ci;
  logic                  is_nl;
  logic [7:0]            follow;
  kind_e                 pair_kind, single_kind;
  logic [4:0]            eff_radix;
  logic [VALUE_BITS-1:0] eff_acc;
  logic [VALUE_BITS-1:0] acc_mul;
  logic                  dig_ok;
  logic [3:0]            dig;
  logic                  again;
  logic                  emit_a, emit_b;
  result_t               res_a, res_b;
  logic [ColW:0]         col_x, col_p1, start_x, start_p1;

  function automatic result_t make_res(input kind_e kind, input logic [31:0] val,
                                       input logic [ColW:0] s, input logic [ColW:0] e);
    result_t       r;
    logic [ColW:0] diff;
    diff    = (e > s) ? e - s : '0;
    r.kind  = kind;
    r.value = val;
    r.start = (32'(s) > 32'd255) ? 8'hff : 8'(s);
    r.len   = (32'(diff) > 32'd255) ? 8'hff : 8'(diff);
    r.last  = 1'b0;
    return r;
  endfunction

  assign ci       = classify(byte_i);
  assign is_nl    = (byte_i == 8'h00) || (byte_i == 8'h0a);
  assign col_x    = {1'b0, col_q};
  assign col_p1   = col_x + 1'b1;
  assign start_x  = {1'b0, start_q};
  assign start_p1 = start_x + 1'b1;

  // second character of a possible two-character operator
  always_comb begin
    follow      = 8'h00;
    pair_kind   = K_POSTINC;
    single_kind = K_ADD;
    case (mode_q)
      M_PLUS:  begin follow = "+"; pair_kind = K_POSTINC; single_kind = K_ADD; end
      M_MINUS: begin follow = "-"; pair_kind = K_PREDEC;  single_kind = K_SUB; end
      M_LT:    begin follow = "<"; pair_kind = K_SHL;     single_kind = K_LT;  end
      M_GT:    begin follow = ">"; pair_kind = K_SHR;     single_kind = K_GT;  end
      default: ;
    endcase
  end

  // a pending leading zero resolves to octal here
  assign eff_radix = (mode_q == M_ZERO) ? 5'd8 : radix_q;
  assign eff_acc   = (mode_q == M_ZERO) ? '0 : acc_q;

  always_comb begin
    dig_ok = 1'b0;
    dig    = 4'd0;
    if (byte_i >= "0" && byte_i <= "9") begin
      dig_ok = 1'b1;
      dig    = 4'(byte_i - "0");
    end else if (eff_radix == 5'd16 && byte_i >= "a" && byte_i <= "f") begin
      dig_ok = 1'b1;
      dig    = 4'(byte_i - "a" + 8'd10);
    end else if (eff_radix == 5'd16 && byte_i >= "A" && byte_i <= "F") begin
      dig_ok = 1'b1;
      dig    = 4'(byte_i - "A" + 8'd10);
    end
  end

  always_comb begin
    case (eff_radix)
      5'd2:    acc_mul = eff_acc << 1;
      5'd8:    acc_mul = eff_acc << 3;
      5'd16:   acc_mul = eff_acc << 4;
      default: acc_mul = (eff_acc << 3) + (eff_acc << 1);
    endcase
  end

  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    radix_d = radix_q;
    col_d   = col_q;
    start_d = start_q;
    again   = 1'b0;
    emit_a  = 1'b0;
    emit_b  = 1'b0;
    res_a   = '0;
    res_b   = '0;

    if (col_q < ColW'(LINE_COLUMNS - 1)) col_d = col_q + 1'b1;

    // finish the pending token, if any
    unique case (mode_q)
      M_DISCARD: begin
        if (is_nl) begin
          mode_d = M_IDLE;
          col_d  = '0;
        end
      end
      M_PLUS, M_MINUS, M_LT, M_GT: begin
        emit_a = 1'b1;
        mode_d = M_IDLE;
        if (byte_i == follow) begin
          res_a = make_res(pair_kind, 32'd0, start_x, col_p1);
        end else begin
          res_a = make_res(single_kind, 32'd0, start_x, start_p1);
          again = 1'b1;
        end
      end
      M_QUOTE: begin
        emit_a = 1'b1;
        mode_d = M_IDLE;
        if (is_nl) begin
          res_a = make_res(K_INT, 32'h20, start_x, start_p1);
          again = 1'b1;
        end else begin
          res_a = make_res(K_INT, (byte_i < 8'h20) ? 32'h20 : 32'(byte_i), start_x, col_p1);
        end
      end
      M_IDENT: begin
        if (ci.cc != CC_IDENT && ci.cc != CC_DIGIT) begin
          emit_a = 1'b1;
          res_a  = make_res(K_IDENT, 32'd0, start_x, col_x);
          mode_d = M_IDLE;
          again  = 1'b1;
        end
      end
      M_ZERO, M_NUMBER: begin
        mode_d = M_NUMBER;
        if (mode_q == M_ZERO && (byte_i == "x" || byte_i == "X")) begin
          acc_d   = '0;
          radix_d = 5'd16;
        end else begin
          radix_d = eff_radix;
          acc_d   = eff_acc;
          if (dig_ok) begin
            acc_d = acc_mul + VALUE_BITS'(dig);
          end else begin
            emit_a = 1'b1;
            mode_d = M_IDLE;
            if (byte_i == "L" || byte_i == "l") begin
              res_a = make_res(K_INT, 32'(eff_acc), start_x, col_p1);
            end else begin
              res_a = make_res(K_INT, 32'(eff_acc), start_x, col_x);
              again = 1'b1;
            end
          end
        end
      end
      M_IDLE:  again = 1'b1;
      default: again = 1'b1;
    endcase

    // scan the byte as the start of a new token
    if (again) begin
      case (ci.cc)
        CC_WS: ;
        CC_TOKEN: begin
          emit_b = 1'b1;
          res_b  = make_res(ci.kind, 32'd0, col_x, col_p1);
        end
        CC_EOL: begin
          emit_b = 1'b1;
          res_b  = make_res(K_EOL, 32'd0, col_x, col_p1);
          if (is_nl) begin
            col_d  = '0;
            mode_d = M_IDLE;
          end else begin
            mode_d = M_DISCARD;
          end
        end
        default: begin
          start_d = col_q;
          acc_d   = '0;
          case (ci.cc)
            CC_PLUS:  mode_d = M_PLUS;
            CC_MINUS: mode_d = M_MINUS;
            CC_LT:    mode_d = M_LT;
            CC_GT:    mode_d = M_GT;
            CC_QUOTE: mode_d = M_QUOTE;
            CC_HEX: begin
              radix_d = 5'd16;
              mode_d  = M_NUMBER;
            end
            CC_BIN: begin
              radix_d = 5'd2;
              mode_d  = M_NUMBER;
            end
            CC_DIGIT: begin
              if (byte_i == "0") begin
                mode_d = M_ZERO;
              end else begin
                radix_d = 5'd10;
                acc_d   = VALUE_BITS'(byte_i - "0");
                mode_d  = M_NUMBER;
              end
            end
            default: mode_d = M_IDENT;
          endcase
        end
      endcase
    end
  end

  // pack the tokens of this byte, marking the final one
  always_comb begin
    scan_o = '0;
    if (step_i) begin
      if (emit_a && emit_b) begin
        scan_o.r0      = res_a;
        scan_o.r1      = res_b;
        scan_o.r1.last = 1'b1;
        scan_o.n       = 2'd2;
      end else if (emit_a || emit_b) begin
        scan_o.r0      = emit_a ? res_a : res_b;
        scan_o.r0.last = 1'b1;
        scan_o.n       = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      acc_q   <= '0;
      radix_q <= 5'd10;
      col_q   <= '0;
      start_q <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      radix_q <= radix_d;
      col_q   <= col_d;
      start_q <= start_d;
    end
  end

endmodule

FILE: hw/rtl/ats_result_fifo.sv
module ats_result_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ats_pkg::scan_out_t push_i,
  input  logic               pop_i,
  output ats_pkg::result_t   head_o,
  output logic               valid_o,
  output logic               room_o
);
  import ats_pkg::*;

  result_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_q, rd_q;
  logic [FifoCntW-1:0]   cnt_q;
  logic [FifoPtrW-1:0]   wr_p1;
  logic                  do_pop;

  assign wr_p1   = wr_q + 1'b1;
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;
  // two free entries cover the worst case of one byte
  assign room_o  = (cnt_q <= FifoCntW'(FifoDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wr_p1] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + FifoPtrW'(push_i.n);
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + FifoCntW'(push_i.n) - FifoCntW'(do_pop);
    end
  end

endmodule

FILE: hw/rtl/assembler_token_scanner.sv
// assembler token scanner
//
// slave channel: one source byte per item on s_axis_tdata. master channel:
// one token per item; tuser carries the token kind, tdata carries value,
// start column and length, tlast marks the final token caused by a byte.
// a byte may cause zero, one or two tokens (a token is closed by the byte
// that follows it, and that byte may then form a token of its own).
//
// path: a byte taken sits in the input register, is scanned from there
// and its tokens pass through the result queue to the master side.
// throughput: one byte per cycle while the queue has room; the per-byte scan
// is a single pass of class decode, shift-add accumulate and length subtract.
// a byte with two tokens drains them one after the other on the master side.
// stalls: tokens wait in a four-entry result queue; the scan step runs only
// while two entries are free, so a stalled receiver backs up into tready
// and no token is ever dropped.
// reset: scanner idle at line start, column 0, radix ten, queue empty.
module assembler_token_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] value, [39:32] start_column,
                                      // [47:40] token_length
  output logic [4:0]  m_axis_tuser,   // [4:0] token_kind
  output logic        m_axis_tlast    // last_of_run
);
  import ats_pkg::*;

  logic      byte_vld_q;
  logic [7:0] byte_q;
  logic      room;
  logic      step;
  logic      in_acc;
  scan_out_t scan;
  result_t   head;

  // scan the held byte when the queue can absorb two tokens
  assign step          = byte_vld_q && room;
  assign s_axis_tready = !byte_vld_q || room;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else begin
      byte_vld_q <= in_acc || (byte_vld_q && !step);
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_acc) byte_q <= s_axis_tdata;
  end

  ats_scan_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (byte_q),
    .scan_o (scan)
  );

  ats_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (scan),
    .pop_i   (m_axis_tready),
    .head_o  (head),
    .valid_o (m_axis_tvalid),
    .room_o  (room)
  );

  assign m_axis_tdata = {head.len, head.start, head.value};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

FILE: hw/rtl/ats_checker.sv
module ats_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [4:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import ats_pkg::*;

  // a pending token stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("token withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("token changed while stalled");

  // value field is only used by integer constants
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != K_INT |-> m_axis_tdata[31:0] == 32'd0)
    else $error("nonzero value on non-integer token");

  // end of line is always one byte long
  a_eol_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == K_EOL |-> m_axis_tdata[47:40] == 8'd1)
    else $error("end of line token with wrong length");

  // no kind code beyond end of line
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= K_EOL)
    else $error("token kind out of range");

endmodule

bind assembler_token_scanner ats_checker u_ats_checker (.*);

FILE: test/assembler_token_scanner_test.sv
module assembler_token_scanner_test;
  import ats_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_BYTES  = 90;
  localparam int SETTLE_CYCLES = 20;

  // coarse byte classes used by the token predictor
  typedef enum logic [3:0] {
    BC_SPACE, BC_EOL, BC_PLUS, BC_MINUS, BC_LESS, BC_GREATER, BC_QUOTE,
    BC_DOLLAR, BC_PERCENT, BC_DIGIT, BC_NAME, BC_SINGLE
  } byte_class_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [7:0]  start;
    logic [7:0]  len;
    logic        last;
  } token_t;

  typedef struct packed {
    bit     typed;
    token_t tok;
  } byte_note_t;

  typedef struct packed {
    logic [7:0] c;
    bit         typed;
    token_t     tok;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // predictor state
  mode_e       scan_state = M_IDLE;
  logic [31:0] number_acc = '0;
  int unsigned number_base = 10;
  logic [7:0]  column = '0;
  logic [7:0]  tok_begin = '0;

  token_t      step_tokens[$];
  token_t      tokens_due[$];
  byte_note_t  byte_notes[$];
  stim_row_t   directed_rows[$];
  logic [7:0]  line_bytes[$];

  int          sender_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          errors = 0;
  int          tokens_checked = 0;
  int          bytes_taken = 0;
  int          lines_sent = 0;
  int          quiet_cycles = 0;
  logic [31:0] kinds_seen = '0;

  string op_chars   = "*/&|~=#@()[],:?\"^{}";
  string pair_chars = "+-<>";
  string hex_chars  = "0123456789abcdefABCDEF";
  string name_chars = "_.abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";

  assembler_token_scanner dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  function automatic byte_class_e byte_class(input logic [7:0] c, output kind_e k);
    k = K_OTHER;
    if (c == 8'h00 || c == 8'h0a) return BC_EOL;
    // control bytes, space and the upper half all count as blanks
    if (c < 8'h20 || c >= 8'h80 || c == " ") return BC_SPACE;
    if (c >= "0" && c <= "9") return BC_DIGIT;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == ".")
      return BC_NAME;
    case (c)
      "!", ";": return BC_EOL;
      "+":      return BC_PLUS;
      "-":      return BC_MINUS;
      "<":      return BC_LESS;
      ">":      return BC_GREATER;
      "'":      return BC_QUOTE;
      "$":      return BC_DOLLAR;
      "%":      return BC_PERCENT;
      "\"":     k = K_STRING;
      "#":      k = K_IMM;
      "&":      k = K_AND;
      "(":      k = K_LPAREN;
      ")":      k = K_RPAREN;
      "*":      k = K_STAR;
      ",":      k = K_COMMA;
      "/":      k = K_SLASH;
      ":":      k = K_COLON;
      "=":      k = K_EQ;
      "?":      k = K_MACRO;
      "@":      k = K_INDIR;
      "[":      k = K_LBRACK;
      "]":      k = K_RBRACK;
      "|":      k = K_OR;
      "~":      k = K_NOT;
      default:  k = K_OTHER;
    endcase
    return BC_SINGLE;
  endfunction

  function automatic token_t make_token(input kind_e k, input logic [31:0] v,
                                        input int s, input int e);
    token_t t;
    int     n;
    n = (e > s) ? e - s : 0;
    t.kind  = k;
    t.value = v;
    t.start = (s > 255) ? 8'd255 : 8'(s);
    t.len   = (n > 255) ? 8'd255 : 8'(n);
    t.last  = 1'b0;
    return t;
  endfunction

  // -1 when the byte is no digit in the current radix; 8 and 9 pass everywhere
  function automatic int digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (number_base == 16 && c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (number_base == 16 && c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  // scan a byte with no token pending
  function automatic void start_from_idle(input logic [7:0] c, input int col);
    kind_e       k;
    byte_class_e bc;
    bc = byte_class(c, k);
    case (bc)
      BC_SPACE: ;
      BC_SINGLE: step_tokens.push_back(make_token(k, '0, col, col + 1));
      BC_EOL: begin
        step_tokens.push_back(make_token(K_EOL, '0, col, col + 1));
        // comment lines are swallowed up to the line end
        if (c == 8'h00 || c == 8'h0a) begin
          column = '0;
          scan_state = M_IDLE;
        end else begin
          scan_state = M_DISCARD;
        end
      end
      default: begin
        tok_begin = 8'(col);
        number_acc = '0;
        case (bc)
          BC_PLUS:    scan_state = M_PLUS;
          BC_MINUS:   scan_state = M_MINUS;
          BC_LESS:    scan_state = M_LT;
          BC_GREATER: scan_state = M_GT;
          BC_QUOTE:   scan_state = M_QUOTE;
          BC_DOLLAR: begin
            number_base = 16;
            scan_state = M_NUMBER;
          end
          BC_PERCENT: begin
            number_base = 2;
            scan_state = M_NUMBER;
          end
          BC_DIGIT: begin
            if (c == "0") begin
              scan_state = M_ZERO;
            end else begin
              number_base = 10;
              number_acc = 32'(c - "0");
              scan_state = M_NUMBER;
            end
          end
          default: scan_state = M_IDENT;
        endcase
      end
    endcase
  endfunction

  // tokens caused by one accepted byte, left in step_tokens
  function automatic void predict_tokens(input logic [7:0] c);
    int          col;
    int          d;
    logic [7:0]  twin;
    kind_e       pair_k;
    kind_e       one_k;
    kind_e       k;
    byte_class_e bc;
    logic        rescan;
    step_tokens.delete();
    col = int'(column);
    rescan = 1'b0;
    twin = 8'h00;
    pair_k = K_OTHER;
    one_k = K_OTHER;
    if (column != 8'd255) column = column + 8'd1;
    case (scan_state)
      M_PLUS: begin
        twin = "+"; pair_k = K_POSTINC; one_k = K_ADD;
      end
      M_MINUS: begin
        twin = "-"; pair_k = K_PREDEC; one_k = K_SUB;
      end
      M_LT: begin
        twin = "<"; pair_k = K_SHL; one_k = K_LT;
      end
      M_GT: begin
        twin = ">"; pair_k = K_SHR; one_k = K_GT;
      end
      default: ;
    endcase

    if (scan_state == M_DISCARD) begin
      if (c == 8'h00 || c == 8'h0a) begin
        scan_state = M_IDLE;
        column = '0;
      end
    end else if (twin != 8'h00) begin
      scan_state = M_IDLE;
      if (c == twin) begin
        step_tokens.push_back(make_token(pair_k, '0, int'(tok_begin), col + 1));
      end else begin
        step_tokens.push_back(make_token(one_k, '0, int'(tok_begin), int'(tok_begin) + 1));
        rescan = 1'b1;
      end
    end else if (scan_state == M_QUOTE) begin
      scan_state = M_IDLE;
      if (c == 8'h00 || c == 8'h0a) begin
        // the line end is not quoted: blank constant, then the line end itself
        step_tokens.push_back(make_token(K_INT, 32'h20, int'(tok_begin),
                                         int'(tok_begin) + 1));
        rescan = 1'b1;
      end else begin
        step_tokens.push_back(make_token(K_INT, (c < 8'h20) ? 32'h20 : 32'(c),
                                         int'(tok_begin), col + 1));
      end
    end else if (scan_state == M_IDENT) begin
      bc = byte_class(c, k);
      if (bc != BC_NAME && bc != BC_DIGIT) begin
        step_tokens.push_back(make_token(K_IDENT, '0, int'(tok_begin), col));
        scan_state = M_IDLE;
        rescan = 1'b1;
      end
    end else if (scan_state == M_ZERO && (c == "x" || c == "X")) begin
      number_acc = '0;
      number_base = 16;
      scan_state = M_NUMBER;
    end else if (scan_state == M_ZERO || scan_state == M_NUMBER) begin
      if (scan_state == M_ZERO) begin
        number_acc = '0;
        number_base = 8;
        scan_state = M_NUMBER;
      end
      d = digit_value(c);
      if (d >= 0) begin
        number_acc = number_acc * number_base + d;
      end else begin
        scan_state = M_IDLE;
        if (c == "L" || c == "l") begin
          step_tokens.push_back(make_token(K_INT, number_acc, int'(tok_begin), col + 1));
        end else begin
          step_tokens.push_back(make_token(K_INT, number_acc, int'(tok_begin), col));
          rescan = 1'b1;
        end
      end
    end else begin
      rescan = 1'b1;
    end

    if (rescan) start_from_idle(c, col);
    if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at token %0d: %s got %0h want %0h", tokens_checked, what, got, want);
    errors++;
  endtask

  // byte side predicts, token side checks in order
  always @(posedge clk_i) begin
    byte_note_t note;
    token_t     got;
    token_t     want;
    int         first;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_tokens(s_axis_tdata);
        note = byte_notes.pop_front();
        first = 0;
        // hand-typed rows replace the first predicted token
        if (note.typed) begin
          tokens_due.push_back(note.tok);
          first = 1;
        end
        for (int i = first; i < step_tokens.size(); i++) tokens_due.push_back(step_tokens[i]);
        bytes_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[39:32], m_axis_tdata[47:40],
               m_axis_tlast};
        kinds_seen[m_axis_tuser] = 1'b1;
        if (tokens_due.size() == 0) begin
          report_mismatch("token with nothing due, kind", 32'(got.kind), '0);
        end else begin
          want = tokens_due.pop_front();
          if (got.kind !== want.kind)
            report_mismatch("kind", 32'(got.kind), 32'(want.kind));
          if (got.value !== want.value) report_mismatch("value", got.value, want.value);
          if (got.start !== want.start)
            report_mismatch("start", 32'(got.start), 32'(want.start));
          if (got.len !== want.len) report_mismatch("length", 32'(got.len), 32'(want.len));
          if (got.last !== want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
        end
        tokens_checked++;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void add_row(input logic [7:0] c, input bit typed, input token_t tok);
    directed_rows.push_back({c, typed, tok});
  endfunction

  // tvalid stays high from one byte to the next unless a gap is drawn
  task automatic send_byte(input logic [7:0] c, input bit typed, input token_t tok);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    byte_notes.push_back({typed, tok});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_for_tokens();
    s_axis_tvalid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // one source line of random pieces, mostly well formed
  function automatic void build_line(input bit long_line);
    int         pieces;
    bit         numeric;
    logic [7:0] pc;
    line_bytes.delete();
    if (long_line) begin
      // identifier running past the last column
      line_bytes.push_back("q");
      repeat (265) line_bytes.push_back(name_chars[$urandom_range(name_chars.len() - 1)]);
    end
    pieces = $urandom_range(1, 10);
    repeat (pieces) begin
      numeric = 1'b0;
      case ($urandom_range(10))
        0: line_bytes.push_back(op_chars[$urandom_range(op_chars.len() - 1)]);
        1: begin
          pc = pair_chars[$urandom_range(3)];
          line_bytes.push_back(pc);
          if ($urandom_range(1)) line_bytes.push_back(pc);
        end
        2: begin
          line_bytes.push_back(8'($urandom_range(49, 57)));
          repeat ($urandom_range(10)) line_bytes.push_back(8'($urandom_range(48, 57)));
          numeric = 1'b1;
        end
        3: begin
          line_bytes.push_back("0");
          repeat ($urandom_range(11)) line_bytes.push_back(8'($urandom_range(48, 57)));
          numeric = 1'b1;
        end
        4: begin
          line_bytes.push_back("0");
          line_bytes.push_back($urandom_range(1) ? "x" : "X");
          repeat ($urandom_range(9)) line_bytes.push_back(hex_chars[$urandom_range(21)]);
          numeric = 1'b1;
        end
        5: begin
          line_bytes.push_back("$");
          if ($urandom_range(2) == 0) begin
            repeat ($urandom_range(8, 9)) line_bytes.push_back("f");
          end else begin
            repeat ($urandom_range(8)) line_bytes.push_back(hex_chars[$urandom_range(21)]);
          end
          numeric = 1'b1;
        end
        6: begin
          line_bytes.push_back("%");
          repeat ($urandom_range(34)) begin
            if ($urandom_range(9) == 0) line_bytes.push_back("9");
            else line_bytes.push_back($urandom_range(1) ? "1" : "0");
          end
          numeric = 1'b1;
        end
        7: begin
          line_bytes.push_back(name_chars[$urandom_range(53)]);
          repeat ($urandom_range(12))
            line_bytes.push_back(name_chars[$urandom_range(name_chars.len() - 1)]);
        end
        8: begin
          line_bytes.push_back("'");
          line_bytes.push_back(8'($urandom_range(255)));
        end
        9: begin
          repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(3))
              0: line_bytes.push_back(" ");
              1: line_bytes.push_back(8'h09);
              2: line_bytes.push_back(8'($urandom_range(128, 255)));
              default: line_bytes.push_back(8'($urandom_range(11, 31)));
            endcase
          end
        end
        default: line_bytes.push_back(8'($urandom_range(255)));
      endcase
      if (numeric && $urandom_range(3) == 0) line_bytes.push_back($urandom_range(1) ? "L" : "l");
      if ($urandom_range(1)) line_bytes.push_back(" ");
    end
    case ($urandom_range(3))
      0: line_bytes.push_back(8'h0a);
      1: line_bytes.push_back(8'h00);
      default: begin
        // comment tail with junk, then the real line end
        line_bytes.push_back($urandom_range(1) ? "!" : ";");
        repeat ($urandom_range(4)) line_bytes.push_back(8'($urandom_range(1, 255)));
        line_bytes.push_back(8'h0a);
      end
    endcase
  endfunction

  initial begin
    int phase_count;
    int idle_mix[4];
    int stall_mix[4];
    idle_mix  = '{0, 86, 0, 15};
    stall_mix = '{0, 0, 86, 15};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed line: pair and single operators, hex, binary, octal and 0x numbers, quote cases, line ends
    add_row(8'h00, 1'b1, token_t'{K_EOL, 32'h0, 8'd0, 8'd1, 1'b1});      // empty line
    add_row("+",   1'b0, '0);
    add_row("+",   1'b1, token_t'{K_POSTINC, 32'h0, 8'd0, 8'd2, 1'b1});
    add_row("-",   1'b0, '0);
    add_row("x",   1'b1, token_t'{K_SUB, 32'h0, 8'd2, 8'd1, 1'b1});     // lone minus
    add_row("<",   1'b0, '0);                                             // closes name x
    add_row("<",   1'b1, token_t'{K_SHL, 32'h0, 8'd4, 8'd2, 1'b1});
    add_row(">",   1'b0, '0);
    add_row(" ",   1'b1, token_t'{K_GT, 32'h0, 8'd6, 8'd1, 1'b1});
    add_row("$",   1'b0, '0);
    add_row("f",   1'b0, '0);
    add_row("F",   1'b0, '0);
    add_row(",",   1'b0, '0);                                             // hex ff, comma
    add_row("%",   1'b0, '0);
    add_row("9",   1'b0, '0);                                             // digit past radix
    add_row("L",   1'b1, token_t'{K_INT, 32'd9, 8'd12, 8'd3, 1'b1});
    add_row("0",   1'b0, '0);
    add_row("7",   1'b0, '0);
    add_row("'",   1'b0, '0);                                             // octal 7 closes
    add_row(8'h01, 1'b1, token_t'{K_INT, 32'h20, 8'd17, 8'd2, 1'b1});   // control byte quoted
    add_row("'",   1'b0, '0);
    add_row(8'h0a, 1'b0, '0);                                             // quote meets newline
    add_row("0",   1'b0, '0);
    add_row("x",   1'b0, '0);
    add_row(";",   1'b0, '0);                                             // empty hex number
    add_row("!",   1'b0, '0);                                             // dropped in comment
    add_row(8'h00, 1'b0, '0);
    foreach (directed_rows[i])
      send_byte(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].tok);

    for (int phase = 0; phase < 4; phase++) begin
      // hold the sender until the scanner has drained
      wait_for_tokens();
      sender_idle_pct = idle_mix[phase];
      sink_stall_pct  = stall_mix[phase];
      phase_count = 0;
      while (phase_count < PHASE_BYTES) begin
        build_line(phase == 0 && phase_count == 0);
        foreach (line_bytes[i]) send_byte(line_bytes[i], 1'b0, '0);
        phase_count += line_bytes.size();
        lines_sent++;
      end
    end

    wait_for_tokens();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("scan run: %0d bytes in %0d lines, %0d tokens checked, %0d mismatches",
             bytes_taken, lines_sent, tokens_checked, errors);
    $display("scan run: %0d of 28 token kinds seen, idle/stall mixes 0/0 86/0 0/86 15/15",
             $countones(kinds_seen));
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: assembler_token_scanner.f
hw/rtl/ats_pkg.sv
hw/rtl/ats_scan_core.sv
hw/rtl/ats_result_fifo.sv
hw/rtl/assembler_token_scanner.sv
hw/rtl/ats_checker.sv
test/assembler_token_scanner_test.sv
